// ----- rtl/hse_pkg.sv -----
// shared types and constants of the heap sort engine
`default_nettype none

package hse_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    localparam logic STATE_LOAD  = 1'b0;
    localparam logic STATE_DRAIN = 1'b1;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last_item;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     final_result;
        logic                     overflowed;
    } out_item_t;

    // what one cell shows its neighbors
    typedef struct packed {
        logic                     valid;
        logic                     ahead;
        logic signed [DATA_W-1:0] value;
    } cell_link_t;

    // command broadcast to the whole row
    typedef struct packed {
        logic insert;
        logic shift;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/heap_sort_engine.sv -----
// top level of the sort engine: cell row, load/drain control and output register
`default_nettype none

// Collects a set of signed 32-bit values and returns them in ascending order.
// Values arrive one per transfer on s_; the transfer with last_item set closes
// the set. Each value is inserted into a row of CAPACITY cells that is kept
// sorted at all times: every cell compares the incoming value with its own and
// either keeps its value, takes the new one, or takes its left neighbor's, so
// the whole row updates at once on an insert and s_ready stays high, one
// value per cycle, while the set is loading. Values past CAPACITY are dropped
// and every result of that set carries overflowed. After the closing transfer
// the row shifts toward cell 0 one step per result, cell 0 feeding the output
// register: the closing transfer moves the engine to drain, and the output
// register then takes cell 0 once it is free; the results follow one per cycle
// while m_ready is high; final_result marks the largest. During the drain
// s_ready is low; once the last result sits in the output register the engine
// takes the next set, even while that result waits.
module heap_sort_engine (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire hse_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output hse_pkg::out_item_t      m_data
);
    import hse_pkg::*;

    logic             state_reg;
    logic             state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             dropped_reg;
    logic             dropped_next;
    logic             set_ovf_reg;
    logic             set_ovf_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    out_item_t        m_data_reg;
    out_item_t        m_data_next;

    logic             s_xfer;
    logic             room;
    logic             out_load;
    cell_cmd_t        cmd;

    cell_link_t       own_w   [CAPACITY];
    cell_link_t       left_w  [CAPACITY];
    cell_link_t       right_w [CAPACITY];

    assign s_ready  = (state_reg == STATE_LOAD);
    assign s_xfer   = s_valid && s_ready;
    assign room     = (count_reg < CNT_W'(CAPACITY));
    // output register free or being emptied this cycle
    assign out_load = (state_reg == STATE_DRAIN) && (!m_valid_reg || m_ready);

    assign cmd.insert = s_xfer && room;
    assign cmd.shift  = out_load;

    // the cell row with its neighbor links
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            if (gi == 0) begin : g_left_edge
                // sentinel: valid and never ahead of the new value
                assign left_w[gi] = '{valid: 1'b1, ahead: 1'b0, value: '0};
            end else begin : g_left
                assign left_w[gi] = own_w[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_right_edge
                assign right_w[gi] = '{valid: 1'b0, ahead: 1'b0, value: '0};
            end else begin : g_right
                assign right_w[gi] = own_w[gi+1];
            end
            hse_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .cmd       (cmd),
                .new_value (s_data.value),
                .left      (left_w[gi]),
                .right     (right_w[gi]),
                .own       (own_w[gi])
            );
        end
    endgenerate

    // control: load, close the set, drain
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        set_ovf_next = set_ovf_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (s_xfer) begin
            if (room) begin
                count_next = count_reg + CNT_W'(1);
            end else begin
                dropped_next = 1'b1;
            end
            if (s_data.last_item) begin
                state_next   = STATE_DRAIN;
                set_ovf_next = dropped_reg || !room;
                count_next   = '0;
                dropped_next = 1'b0;
            end
        end

        if (out_load) begin
            // cell 0 always holds a value while draining
            m_valid_next             = 1'b1;
            m_data_next.sorted_value = own_w[0].value;
            m_data_next.final_result = !own_w[1].valid;
            m_data_next.overflowed   = set_ovf_reg;
            if (!own_w[1].valid) begin
                state_next = STATE_LOAD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= STATE_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            set_ovf_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            set_ovf_reg <= set_ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // the fill count never passes the row length
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

    // a value is dropped only once the row is full
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        dropped_reg |-> (count_reg == CNT_W'(CAPACITY)))
        else $error("drop flagged with room left");

    // no gap at the head of the row: cell 1 is occupied only if cell 0 is
    a_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        !own_w[0].valid |-> !own_w[1].valid)
        else $error("gap at the head of the cell row");

    // while draining, cell 0 holds the next result
    a_drain_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == STATE_DRAIN) |-> own_w[0].valid)
        else $error("drain with empty cell row");

endmodule

`default_nettype wire

// ----- rtl/hse_cell.sv -----
// one cell of the sorting row: holds one value, ascending from cell 0
`default_nettype none

module hse_cell (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire hse_pkg::cell_cmd_t               cmd,
    input  wire logic signed [hse_pkg::DATA_W-1:0] new_value,
    input  wire hse_pkg::cell_link_t              left,
    input  wire hse_pkg::cell_link_t              right,
    output hse_pkg::cell_link_t                   own
);
    import hse_pkg::*;

    logic                     valid_reg;
    logic                     valid_next;
    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic                     ahead;

    // new value goes ahead of this one (strict, so ties stay in arrival order)
    assign ahead = valid_reg && (new_value < value_reg);

    assign own.valid = valid_reg;
    assign own.ahead = ahead;
    assign own.value = value_reg;

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (cmd.insert) begin
            if (valid_reg) begin
                if (ahead) begin
                    value_next = left.ahead ? left.value : new_value;
                end
            end else if (left.ahead) begin
                valid_next = 1'b1;
                value_next = left.value;
            end else if (left.valid) begin
                // first empty cell behind the last smaller-or-equal value
                valid_next = 1'b1;
                value_next = new_value;
            end
        end else if (cmd.shift) begin
            valid_next = right.valid;
            value_next = right.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// self-checking testbench for the heap sort engine
`timescale 1ns / 1ps

// keeps its own copy of the set being loaded and the sorted results it expects
class sort_scoreboard;
    logic signed [hse_pkg::DATA_W-1:0] held_values[hse_pkg::CAPACITY];
    int                                 held_count;
    bit                                 set_dropped;
    hse_pkg::out_item_t                 expected_sorted[$];
    int                                 errors;

    function new();
        held_count  = 0;
        set_dropped = 0;
        errors      = 0;
    endfunction

    task report(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    // an accepted input transfer; a closing item queues the whole sorted set
    function void note_value(hse_pkg::in_item_t item);
        hse_pkg::out_item_t                res;
        logic signed [hse_pkg::DATA_W-1:0] key;
        int                                j;
        if (held_count < hse_pkg::CAPACITY) begin
            held_values[held_count] = item.value;
            held_count++;
        end else begin
            set_dropped = 1;
        end
        if (!item.last_item) return;
        // insertion sort, ascending, signed compare
        for (int i = 1; i < held_count; i++) begin
            key = held_values[i];
            j = i - 1;
            while (j >= 0 && held_values[j] > key) begin
                held_values[j + 1] = held_values[j];
                j--;
            end
            held_values[j + 1] = key;
        end
        for (int k = 0; k < held_count; k++) begin
            res.sorted_value = held_values[k];
            res.final_result = (k == held_count - 1);
            res.overflowed   = set_dropped;
            expected_sorted.push_back(res);
        end
        held_count  = 0;
        set_dropped = 0;
    endfunction

    task check_sorted(hse_pkg::out_item_t got);
        hse_pkg::out_item_t exp;
        if (expected_sorted.size() == 0) begin
            report($sformatf("unexpected result value %0d", got.sorted_value));
            return;
        end
        exp = expected_sorted.pop_front();
        if (got.sorted_value !== exp.sorted_value)
            report($sformatf("sorted_value %0d, expected %0d",
                             got.sorted_value, exp.sorted_value));
        if (got.final_result !== exp.final_result)
            report($sformatf("final_result %b, expected %b",
                             got.final_result, exp.final_result));
        if (got.overflowed !== exp.overflowed)
            report($sformatf("overflowed %b, expected %b",
                             got.overflowed, exp.overflowed));
    endtask
endclass

module testbench;
    import hse_pkg::*;

    // cycles with no transfer on either side before the run is declared hung;
    // the longest legal sender gap or receiver stall stays far below this limit
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEM_TARGET    = 230;

    // value mixes for a set
    localparam int MIX_WIDE    = 0;
    localparam int MIX_TIES    = 1;
    localparam int MIX_CORNERS = 2;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    sort_scoreboard sb = new();

    int items_sent = 0;
    int burst_left = 0;
    int rx_mode    = 0;
    int rx_left    = 0;
    int idle_count = 0;

    heap_sort_engine i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // monitors sample at the rising edge, before the block updates its outputs
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_value(s_data);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_sorted(m_data);
    end

    // watchdog: counts cycles in which neither side moves a transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_count = 0;
            else
                idle_count++;
            if (idle_count >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // receiver back-pressure: switches between always ready, coin flip,
    // mostly stalled and a fixed duty pattern, each for a random stretch
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(10, 80);
        end
        rx_left--;
        case (rx_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= ($urandom_range(0, 1) == 1);
            end
            2: begin
                m_ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                m_ready <= ((rx_left % 7) < 4);
            end
        endcase
    end

    // one input transfer; called and returns at a falling edge
    task send_item(logic signed [DATA_W-1:0] value, logic closing);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            // now and then a long burst with no gaps at all
            burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 24);
        end
        s_valid          <= 1'b1;
        s_data.value     <= value;
        s_data.last_item <= closing;
        do
            @(posedge aclk);
        while (!s_ready);
        @(negedge aclk);
        burst_left--;
        items_sent++;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value(int mix);
        logic signed [DATA_W-1:0] v;
        case (mix)
            MIX_TIES: begin
                v = $signed($urandom_range(0, 6)) - 3;
            end
            MIX_CORNERS: begin
                case ($urandom_range(0, 4))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7FFF_FFFF;
                    2: v = '0;
                    3: v = '1;
                    default: v = $urandom;
                endcase
            end
            default: begin
                v = $urandom;
            end
        endcase
        return v;
    endfunction

    // a random set of the given size, closing item last
    task send_set(int size, int mix);
        for (int k = 0; k < size; k++)
            send_item(pick_value(mix), k == size - 1);
    endtask

    initial begin
        int size;
        int mix;
        int r;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: one-item sets at both extremes
        send_item(32'sh7FFF_FFFF, 1'b1);
        send_item(32'sh8000_0000, 1'b1);
        // extremes and values around zero in one set
        send_item(32'sh7FFF_FFFF, 1'b0);
        send_item(32'sh8000_0000, 1'b0);
        send_item(0, 1'b0);
        send_item(-1, 1'b0);
        send_item(1, 1'b1);
        // repeated values
        send_item(5, 1'b0);
        send_item(-5, 1'b0);
        send_item(5, 1'b0);
        send_item(5, 1'b0);
        send_item(-5, 1'b1);
        // descending input
        send_item(300, 1'b0);
        send_item(200, 1'b0);
        send_item(100, 1'b0);
        send_item(-100, 1'b1);
        // alternating bit patterns
        send_item(32'sh5555_5555, 1'b0);
        send_item(32'shAAAA_AAAA, 1'b1);

        // a full store, then one that overflows including the closing item
        send_set(CAPACITY, MIX_WIDE);
        send_set(CAPACITY + 3, MIX_CORNERS);

        // random sets, mostly small, now and then near or past capacity
        while (items_sent < ITEM_TARGET) begin
            r    = $urandom_range(0, 15);
            size = (r == 0) ? $urandom_range(CAPACITY - 4, CAPACITY + 6)
                            : $urandom_range(1, 12);
            r    = $urandom_range(0, 9);
            mix  = (r < 6) ? MIX_WIDE : (r < 8) ? MIX_TIES : MIX_CORNERS;
            send_set(size, mix);
        end
        s_valid <= 1'b0;

        // drain; a hang here is caught by the watchdog
        while (sb.expected_sorted.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
